### hw/rtl/tile_residency_topk_policy_core_assert.svh
// Assertion macros shared by the checker of the tile residency policy core.
`ifndef TILE_RESIDENCY_TOPK_POLICY_CORE_ASSERT_SVH
`define TILE_RESIDENCY_TOPK_POLICY_CORE_ASSERT_SVH

// The consequent must hold in the cycle of the antecedent.
`define TRP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/trp_pkg.sv
// Package of the tile residency policy core: sizes, codes and shared types.
package trp_pkg;

   localparam int MAX_TILES   = 32;
   localparam int COORD_WIDTH = 24;
   localparam int ID_WIDTH    = 5;
   localparam int RANK_WIDTH  = 6;
   localparam int ACT_WIDTH   = 3;
   localparam int KIND_WIDTH  = 2;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int SQ_WIDTH    = 2 * COORD_WIDTH + 1;
   localparam int SUM_WIDTH   = 2 * COORD_WIDTH + 2;
   localparam int ROOT_WIDTH  = SUM_WIDTH / 2;
   localparam int SCORE_WIDTH = COORD_WIDTH + 3;
   localparam int GEOM_WIDTH  = 4 * COORD_WIDTH;

   localparam logic [ACT_WIDTH-1:0] ACT_LOAD   = 3'd0;
   localparam logic [ACT_WIDTH-1:0] ACT_MARK   = 3'd1;
   localparam logic [ACT_WIDTH-1:0] ACT_UPDATE = 3'd2;
   localparam logic [ACT_WIDTH-1:0] ACT_QUERY  = 3'd3;
   localparam logic [ACT_WIDTH-1:0] ACT_CLEAR  = 3'd4;

   localparam logic [KIND_WIDTH-1:0] KIND_PAGE_IN  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_PAGE_OUT = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_DONE     = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_QUERY    = 2'd3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_DISTANCE = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HYSTERESIS   = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BUDGET       = 2'd2;

   localparam logic [RANK_WIDTH-1:0] BUDGET_RESET = RANK_WIDTH'(MAX_TILES);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_SCORE,
      ST_RANK_LOAD,
      ST_RANK,
      ST_SCAN_IN,
      ST_SCAN_OUT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                          cand;
      logic [ID_WIDTH-1:0]           id;
      logic signed [SCORE_WIDTH-1:0] score;
   } token_type;

   typedef struct packed {
      logic                          load;
      logic                          mark;
      logic                          clear;
      logic                          score_wr;
      logic                          rank_start;
      logic                          rank_shift;
      logic                          commit;
      logic [ID_WIDTH-1:0]           sel;
      logic                          cand;
      logic signed [SCORE_WIDTH-1:0] score;
      logic [RANK_WIDTH-1:0]         budget;
   } cell_cmd_type;

   typedef struct packed {
      logic loaded;
      logic resident;
      logic visible;
      logic want;
   } cell_stat_type;

endpackage

### hw/rtl/trp_ram.sv
// Generic single write port RAM with a registered read port.
module trp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/trp_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module trp_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [trp_pkg::SUM_WIDTH-1:0]    value,
   output logic                             done,
   output logic [trp_pkg::ROOT_WIDTH-1:0]   root
);

   localparam int NW = trp_pkg::SUM_WIDTH;
   localparam int RW = trp_pkg::SUM_WIDTH + 1;
   localparam int CW = $clog2(trp_pkg::ROOT_WIDTH);

   logic [NW-1:0] n_ff, n_in;
   logic [RW-1:0] r_ff, r_in;
   logic [NW-1:0] bit_ff, bit_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] trial;

   always_comb begin
      trial   = r_ff + RW'(bit_ff);
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = value;
         r_in    = '0;
         bit_in  = NW'(1) << (NW - 2);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (RW'(n_ff) >= trial) begin
            n_in = n_ff - NW'(trial);
            r_in = (r_ff >> 1) + RW'(bit_ff);
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(trp_pkg::ROOT_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = r_ff[trp_pkg::ROOT_WIDTH-1:0];

endmodule

### hw/rtl/trp_cell.sv
// One tile cell: flags, score and rank, passing its ranking token along the ring.
module trp_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [trp_pkg::ID_WIDTH-1:0]    cell_id,
   input  trp_pkg::cell_cmd_type           cmd,
   input  trp_pkg::token_type              token_in,
   output trp_pkg::token_type              token_out,
   output trp_pkg::cell_stat_type          stat
);

   logic                                  loaded_ff, resident_ff, visible_ff, cand_ff;
   logic signed [trp_pkg::SCORE_WIDTH-1:0] score_ff;
   logic [trp_pkg::RANK_WIDTH-1:0]         rank_ff;
   trp_pkg::token_type                     tok_ff;
   logic                                   hit, beats, want;

   always_comb begin
      hit   = (cmd.sel == cell_id);
      beats = tok_ff.cand && (($signed(tok_ff.score) > score_ff) ||
              (($signed(tok_ff.score) == score_ff) && (tok_ff.id < cell_id)));
      want  = cand_ff && (rank_ff < cmd.budget);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= 1'b0;
         resident_ff <= 1'b0;
         visible_ff  <= 1'b0;
         cand_ff     <= 1'b0;
      end else if (cmd.clear) begin
         loaded_ff   <= 1'b0;
         resident_ff <= 1'b0;
         visible_ff  <= 1'b0;
      end else begin
         if (cmd.load && hit) begin
            loaded_ff <= 1'b1;
         end
         if (cmd.mark && hit) begin
            visible_ff <= 1'b1;
         end
         if (cmd.score_wr && hit) begin
            cand_ff <= cmd.cand;
         end
         if (cmd.commit) begin
            resident_ff <= want;
            visible_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.score_wr && hit) begin
         score_ff <= cmd.score;
      end
      if (cmd.rank_start) begin
         rank_ff      <= '0;
         tok_ff.cand  <= cand_ff;
         tok_ff.id    <= cell_id;
         tok_ff.score <= score_ff;
      end else if (cmd.rank_shift) begin
         rank_ff <= rank_ff + trp_pkg::RANK_WIDTH'(beats);
         tok_ff  <= token_in;
      end
   end

   assign token_out     = tok_ff;
   assign stat.loaded   = loaded_ff;
   assign stat.resident = resident_ff;
   assign stat.visible  = visible_ff;
   assign stat.want     = want;

endmodule

### hw/rtl/tile_residency_topk_policy_core.sv
// Top level of the tile residency policy core.
// Load, mark visible, clear table and query act in the cycle they are taken; a query
// answer enters the output register in that cycle. An update frame walks the tiles
// one at a time through the bit-serial square root unit, then ranks as the score
// tokens travel once round the ring of tile cells, then scans the tiles one at a
// time for page-in and then page-out requests and ends with the done request; the
// scans and the done request wait while the result side stalls. Most of the time
// of a frame goes to the square root unit. No request is taken while an update is
// in progress.
module tile_residency_topk_policy_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [trp_pkg::ACT_WIDTH-1:0]            req_action,
   input  logic [trp_pkg::ID_WIDTH-1:0]             req_tile_id,
   input  logic signed [trp_pkg::COORD_WIDTH-1:0]   req_pos_x,
   input  logic signed [trp_pkg::COORD_WIDTH-1:0]   req_pos_y,
   input  logic signed [trp_pkg::COORD_WIDTH-1:0]   req_pos_z,
   input  logic [trp_pkg::COORD_WIDTH-1:0]          req_radius,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [trp_pkg::KIND_WIDTH-1:0]           rsp_kind,
   output logic [trp_pkg::ID_WIDTH-1:0]             rsp_result_id,
   output logic                                     rsp_is_resident,
   output logic [trp_pkg::RANK_WIDTH-1:0]           rsp_resident_total,
   output logic                                     rsp_last,
   input  logic                                     csr_write,
   input  logic [trp_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [trp_pkg::COORD_WIDTH-1:0]          csr_wdata
);

   localparam int CW  = trp_pkg::COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int SW  = trp_pkg::SCORE_WIDTH;
   localparam int RW  = trp_pkg::RANK_WIDTH;
   localparam int IW  = trp_pkg::ID_WIDTH;
   localparam int NT  = trp_pkg::MAX_TILES;

   trp_pkg::state_type      state_ff, state_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [IW-1:0]           step_ff, step_in;
   logic [RW-1:0]           count_ff, count_in;
   logic [CW-1:0]           max_dist_ff, hyst_ff;
   logic [RW-1:0]           budget_ff;
   logic signed [CW-1:0]    eye_x_ff, eye_y_ff, eye_z_ff;
   logic [trp_pkg::SQ_WIDTH-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [CW-1:0]           rad_ff;
   logic [DW-1:0]           dist_ff;

   logic                    rsp_valid_ff;
   logic [trp_pkg::KIND_WIDTH-1:0] rsp_kind_ff;
   logic [IW-1:0]           rsp_id_ff;
   logic                    rsp_res_ff;
   logic [RW-1:0]           rsp_total_ff;
   logic                    rsp_last_ff;

   logic                    req_fire, out_free;
   logic                    emit_valid, emit_res, emit_last;
   logic [trp_pkg::KIND_WIDTH-1:0] emit_kind;
   logic [IW-1:0]           emit_id;
   logic [RW-1:0]           emit_total;
   logic                    ram_we;
   logic [trp_pkg::GEOM_WIDTH-1:0] ram_rdata;
   logic                    sqrt_start, sqrt_done;
   logic [trp_pkg::ROOT_WIDTH-1:0] sqrt_root;
   trp_pkg::cell_cmd_type   cmd;
   trp_pkg::token_type      tokens [NT];
   trp_pkg::cell_stat_type  stats [NT];
   trp_pkg::cell_stat_type  cur, qst;

   logic signed [DW-1:0]    dx, dy, dz;
   logic [DW-1:0]           ax, ay, az;
   logic [2*DW-1:0]         px, py, pz;
   logic signed [DW:0]      diff;
   logic [DW-1:0]           dist_val;
   logic                    in_range, need_in, need_out, last_idx;

   assign req_fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != trp_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);

   trp_ram #(.WIDTH(trp_pkg::GEOM_WIDTH), .DEPTH(NT)) u_geom (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_tile_id),
      .wdata ({req_pos_x, req_pos_y, req_pos_z, req_radius}),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   trp_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (trp_pkg::SUM_WIDTH'(sqx_ff) + trp_pkg::SUM_WIDTH'(sqy_ff)
              + trp_pkg::SUM_WIDTH'(sqz_ff)),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   for (genvar k = 0; k < NT; k++) begin : g_cell
      trp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (IW'(k)),
         .cmd       (cmd),
         .token_in  (tokens[(k == 0) ? NT - 1 : k - 1]),
         .token_out (tokens[k]),
         .stat      (stats[k])
      );
   end

   always_comb begin
      cur      = stats[idx_ff];
      qst      = stats[req_tile_id];
      in_range = ({1'b0, req_tile_id} < (IW + 1)'(NT));
      last_idx = (idx_ff == IW'(NT - 1));
      need_in  = cur.want && !cur.resident;
      need_out = !cur.want && cur.resident;

      dx = $signed({ram_rdata[4*CW-1], ram_rdata[4*CW-1:3*CW]})
           - $signed({eye_x_ff[CW-1], eye_x_ff});
      dy = $signed({ram_rdata[3*CW-1], ram_rdata[3*CW-1:2*CW]})
           - $signed({eye_y_ff[CW-1], eye_y_ff});
      dz = $signed({ram_rdata[2*CW-1], ram_rdata[2*CW-1:CW]})
           - $signed({eye_z_ff[CW-1], eye_z_ff});
      ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
      ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
      az = dz[DW-1] ? DW'(-dz) : DW'(dz);
      px = ax * ax;
      py = ay * ay;
      pz = az * az;

      diff     = $signed({1'b0, sqrt_root}) - $signed({2'b00, rad_ff});
      dist_val = diff[DW] ? '0 : diff[DW-1:0];

      state_in   = state_ff;
      idx_in     = idx_ff;
      step_in    = step_ff;
      count_in   = count_ff;
      ram_we     = 1'b0;
      sqrt_start = 1'b0;
      emit_valid = 1'b0;
      emit_kind  = trp_pkg::KIND_DONE;
      emit_id    = idx_ff;
      emit_res   = 1'b0;
      emit_total = '0;
      emit_last  = 1'b0;
      cmd        = '0;
      cmd.sel    = idx_ff;
      cmd.budget = budget_ff;
      cmd.cand   = cur.loaded && cur.visible &&
                   !((max_dist_ff != '0) && (dist_ff > {1'b0, max_dist_ff}));
      cmd.score  = -$signed({2'b00, dist_ff}) +
                   (cur.resident ? $signed({3'b000, hyst_ff}) : SW'(0));

      unique case (state_ff)
         trp_pkg::ST_IDLE: begin
            cmd.sel = req_tile_id;
            if (req_fire) begin
               unique case (req_action)
                  trp_pkg::ACT_LOAD: begin
                     ram_we   = in_range;
                     cmd.load = in_range;
                  end
                  trp_pkg::ACT_MARK: begin
                     cmd.mark = in_range;
                  end
                  trp_pkg::ACT_UPDATE: begin
                     state_in = trp_pkg::ST_READ;
                     idx_in   = '0;
                  end
                  trp_pkg::ACT_QUERY: begin
                     emit_valid = 1'b1;
                     emit_kind  = trp_pkg::KIND_QUERY;
                     emit_id    = req_tile_id;
                     emit_res   = in_range && qst.loaded && qst.resident;
                     emit_last  = 1'b1;
                  end
                  trp_pkg::ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         trp_pkg::ST_READ: begin
            state_in = trp_pkg::ST_SQUARE;
         end
         trp_pkg::ST_SQUARE: begin
            state_in = trp_pkg::ST_SUM;
         end
         trp_pkg::ST_SUM: begin
            sqrt_start = 1'b1;
            state_in   = trp_pkg::ST_ROOT;
         end
         trp_pkg::ST_ROOT: begin
            if (sqrt_done) begin
               state_in = trp_pkg::ST_SCORE;
            end
         end
         trp_pkg::ST_SCORE: begin
            cmd.score_wr = 1'b1;
            if (last_idx) begin
               state_in = trp_pkg::ST_RANK_LOAD;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = trp_pkg::ST_READ;
            end
         end
         trp_pkg::ST_RANK_LOAD: begin
            cmd.rank_start = 1'b1;
            step_in        = '0;
            state_in       = trp_pkg::ST_RANK;
         end
         trp_pkg::ST_RANK: begin
            cmd.rank_shift = 1'b1;
            step_in        = step_ff + IW'(1);
            if (step_ff == IW'(NT - 1)) begin
               state_in = trp_pkg::ST_SCAN_IN;
               idx_in   = '0;
               count_in = '0;
            end
         end
         trp_pkg::ST_SCAN_IN: begin
            if (!need_in || out_free) begin
               emit_valid = need_in;
               emit_kind  = trp_pkg::KIND_PAGE_IN;
               count_in   = count_ff + RW'(cur.want);
               if (last_idx) begin
                  idx_in   = '0;
                  state_in = trp_pkg::ST_SCAN_OUT;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         trp_pkg::ST_SCAN_OUT: begin
            if (!need_out || out_free) begin
               emit_valid = need_out;
               emit_kind  = trp_pkg::KIND_PAGE_OUT;
               if (last_idx) begin
                  state_in = trp_pkg::ST_DONE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         trp_pkg::ST_DONE: begin
            if (out_free) begin
               emit_valid = 1'b1;
               emit_kind  = trp_pkg::KIND_DONE;
               emit_id    = '0;
               emit_total = count_ff;
               emit_last  = 1'b1;
               cmd.commit = 1'b1;
               state_in   = trp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trp_pkg::ST_IDLE;
         idx_ff       <= '0;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_dist_ff  <= '0;
         hyst_ff      <= '0;
         budget_ff    <= trp_pkg::BUDGET_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         if (out_free) begin
            rsp_valid_ff <= emit_valid;
         end
         if (csr_write) begin
            unique case (csr_index)
               trp_pkg::CSR_MAX_DISTANCE: max_dist_ff <= csr_wdata;
               trp_pkg::CSR_HYSTERESIS:   hyst_ff     <= csr_wdata;
               trp_pkg::CSR_BUDGET:       budget_ff   <= csr_wdata[RW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_kind_ff  <= emit_kind;
         rsp_id_ff    <= emit_id;
         rsp_res_ff   <= emit_res;
         rsp_total_ff <= emit_total;
         rsp_last_ff  <= emit_last;
      end
      if (req_fire && (req_action == trp_pkg::ACT_UPDATE)) begin
         eye_x_ff <= req_pos_x;
         eye_y_ff <= req_pos_y;
         eye_z_ff <= req_pos_z;
      end
      if (state_ff == trp_pkg::ST_SQUARE) begin
         sqx_ff <= px[trp_pkg::SQ_WIDTH-1:0];
         sqy_ff <= py[trp_pkg::SQ_WIDTH-1:0];
         sqz_ff <= pz[trp_pkg::SQ_WIDTH-1:0];
         rad_ff <= ram_rdata[CW-1:0];
      end
      if (sqrt_done) begin
         dist_ff <= dist_val;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_result_id      = rsp_id_ff;
   assign rsp_is_resident    = rsp_res_ff;
   assign rsp_resident_total = rsp_total_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

### hw/rtl/trp_checker.sv
// Port checker for the tile residency policy core, bound to the top level.
`include "tile_residency_topk_policy_core_assert.svh"

module trp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [trp_pkg::KIND_WIDTH-1:0]     rsp_kind,
   input logic [trp_pkg::ID_WIDTH-1:0]       rsp_result_id,
   input logic                               rsp_is_resident,
   input logic [trp_pkg::RANK_WIDTH-1:0]     rsp_resident_total,
   input logic                               rsp_last
);

   `TRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_result_id) && $stable(rsp_resident_total), "A stalled request changed.")

   `TRP_ASSERT_SAME(a_done_form, rsp_valid && (rsp_kind == trp_pkg::KIND_DONE), rsp_last && (rsp_result_id == '0) && !rsp_is_resident, "Malformed frame done request.")

   `TRP_ASSERT_SAME(a_page_not_last, rsp_valid && ((rsp_kind == trp_pkg::KIND_PAGE_IN) || (rsp_kind == trp_pkg::KIND_PAGE_OUT)), !rsp_last && !rsp_is_resident && (rsp_resident_total == '0), "A paging request was marked last.")

   `TRP_ASSERT_SAME(a_total_range, rsp_valid, rsp_resident_total <= trp_pkg::RANK_WIDTH'(trp_pkg::MAX_TILES), "Resident count beyond table size.")

endmodule

bind tile_residency_topk_policy_core trp_checker u_trp_checker (.*);

### sim/tb_top.sv
// Self-checking testbench of the tile residency policy core, with random requests and stalls.
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic [trp_pkg::ACT_WIDTH-1:0]          action;
      logic [trp_pkg::ID_WIDTH-1:0]           tile_id;
      logic signed [trp_pkg::COORD_WIDTH-1:0] pos_x;
      logic signed [trp_pkg::COORD_WIDTH-1:0] pos_y;
      logic signed [trp_pkg::COORD_WIDTH-1:0] pos_z;
      logic [trp_pkg::COORD_WIDTH-1:0]        radius;
   } request_type;

   typedef struct {
      logic [trp_pkg::KIND_WIDTH-1:0] kind;
      logic [trp_pkg::ID_WIDTH-1:0]   result_id;
      logic                           is_resident;
      logic [trp_pkg::RANK_WIDTH-1:0] resident_total;
      logic                           last;
   } residency_event_type;

   class residency_scoreboard;
      bit loaded[trp_pkg::MAX_TILES];
      bit resident[trp_pkg::MAX_TILES];
      bit visible[trp_pkg::MAX_TILES];
      longint cen_x[trp_pkg::MAX_TILES];
      longint cen_y[trp_pkg::MAX_TILES];
      longint cen_z[trp_pkg::MAX_TILES];
      longint rad[trp_pkg::MAX_TILES];
      longint unsigned max_dist;
      longint hyst;
      int unsigned budget;
      residency_event_type pending[$];

      function new();
         max_dist = 0;
         hyst = 0;
         budget = trp_pkg::MAX_TILES;
      endfunction

      function longint unsigned root_floor(longint unsigned n);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void write_reg(logic [trp_pkg::CSR_IDX_WIDTH-1:0] idx,
                              logic [trp_pkg::COORD_WIDTH-1:0] v);
         case (idx)
            trp_pkg::CSR_MAX_DISTANCE: max_dist = v;
            trp_pkg::CSR_HYSTERESIS: hyst = v;
            trp_pkg::CSR_BUDGET: budget = v[trp_pkg::RANK_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void push_event(logic [trp_pkg::KIND_WIDTH-1:0] k, int id, bit res, int total,
                               bit lst);
         residency_event_type e;
         e.kind = k;
         e.result_id = trp_pkg::ID_WIDTH'(id);
         e.is_resident = res;
         e.resident_total = trp_pkg::RANK_WIDTH'(total);
         e.last = lst;
         pending = {pending, e};
      endfunction

      function void note_request(request_type r);
         bit cand[trp_pkg::MAX_TILES];
         bit want[trp_pkg::MAX_TILES];
         longint score[trp_pkg::MAX_TILES];
         longint dx, dy, dz, span;
         int unsigned rank;
         int count;
         case (r.action)
            trp_pkg::ACT_LOAD: begin
               loaded[r.tile_id] = 1;
               cen_x[r.tile_id] = $signed(r.pos_x);
               cen_y[r.tile_id] = $signed(r.pos_y);
               cen_z[r.tile_id] = $signed(r.pos_z);
               rad[r.tile_id] = r.radius;
            end
            trp_pkg::ACT_MARK: visible[r.tile_id] = 1;
            trp_pkg::ACT_QUERY:
               push_event(trp_pkg::KIND_QUERY, r.tile_id,
                          loaded[r.tile_id] && resident[r.tile_id], 0, 1);
            trp_pkg::ACT_CLEAR: begin
               foreach (loaded[i]) begin
                  loaded[i] = 0;
                  resident[i] = 0;
                  visible[i] = 0;
               end
            end
            trp_pkg::ACT_UPDATE: begin
               for (int i = 0; i < trp_pkg::MAX_TILES; i++) begin
                  cand[i] = 0;
                  score[i] = 0;
                  if (loaded[i] && visible[i]) begin
                     dx = cen_x[i] - $signed(r.pos_x);
                     dy = cen_y[i] - $signed(r.pos_y);
                     dz = cen_z[i] - $signed(r.pos_z);
                     span = longint'(root_floor(dx * dx + dy * dy + dz * dz)) - rad[i];
                     if (span < 0) span = 0;
                     if (!(max_dist != 0 && span > longint'(max_dist))) begin
                        score[i] = resident[i] ? hyst - span : -span;
                        cand[i] = 1;
                     end
                  end
               end
               for (int i = 0; i < trp_pkg::MAX_TILES; i++) begin
                  rank = 0;
                  want[i] = 0;
                  if (cand[i]) begin
                     for (int j = 0; j < trp_pkg::MAX_TILES; j++)
                        if (j != i && cand[j] &&
                            (score[j] > score[i] || (score[j] == score[i] && j < i)))
                           rank++;
                     want[i] = rank < budget;
                  end
               end
               for (int i = 0; i < trp_pkg::MAX_TILES; i++)
                  if (want[i] && !resident[i]) push_event(trp_pkg::KIND_PAGE_IN, i, 0, 0, 0);
               for (int i = 0; i < trp_pkg::MAX_TILES; i++)
                  if (!want[i] && resident[i]) push_event(trp_pkg::KIND_PAGE_OUT, i, 0, 0, 0);
               count = 0;
               for (int i = 0; i < trp_pkg::MAX_TILES; i++) begin
                  resident[i] = want[i];
                  visible[i] = 0;
                  if (want[i]) count++;
               end
               push_event(trp_pkg::KIND_DONE, 0, 0, count, 1);
            end
            default: ;
         endcase
      endfunction

      function string check_result(residency_event_type g);
         residency_event_type e;
         if (pending.size() == 0)
            return $sformatf("unexpected result kind %0d id %0d", g.kind, g.result_id);
         e = pending.pop_front();
         if (g.kind !== e.kind || g.result_id !== e.result_id ||
             g.is_resident !== e.is_resident || g.resident_total !== e.resident_total ||
             g.last !== e.last)
            return $sformatf(
               "got kind %0d id %0d res %0d total %0d last %0d, want %0d %0d %0d %0d %0d",
               g.kind, g.result_id, g.is_resident, g.resident_total, g.last,
               e.kind, e.result_id, e.is_resident, e.resident_total, e.last);
         return "";
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [trp_pkg::ACT_WIDTH-1:0] req_action;
   logic [trp_pkg::ID_WIDTH-1:0] req_tile_id;
   logic signed [trp_pkg::COORD_WIDTH-1:0] req_pos_x;
   logic signed [trp_pkg::COORD_WIDTH-1:0] req_pos_y;
   logic signed [trp_pkg::COORD_WIDTH-1:0] req_pos_z;
   logic [trp_pkg::COORD_WIDTH-1:0] req_radius;
   logic rsp_valid;
   logic rsp_stall;
   logic [trp_pkg::KIND_WIDTH-1:0] rsp_kind;
   logic [trp_pkg::ID_WIDTH-1:0] rsp_result_id;
   logic rsp_is_resident;
   logic [trp_pkg::RANK_WIDTH-1:0] rsp_resident_total;
   logic rsp_last;
   logic csr_write;
   logic [trp_pkg::CSR_IDX_WIDTH-1:0] csr_index;
   logic [trp_pkg::COORD_WIDTH-1:0] csr_wdata;

   residency_scoreboard board = new();
   int mismatches = 0;
   int sent = 0;
   int burst_left = 0;
   int stall_mode = 0;

   tile_residency_topk_policy_core dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= ($urandom_range(0, 19) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      residency_event_type g;
      string msg;
      if (!reset && rsp_valid && !rsp_stall) begin
         g.kind = rsp_kind;
         g.result_id = rsp_result_id;
         g.is_resident = rsp_is_resident;
         g.resident_total = rsp_resident_total;
         g.last = rsp_last;
         msg = board.check_result(g);
         if (msg != "") report(msg);
      end
   end

   task automatic send(request_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 12));
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      req_action <= r.action;
      req_tile_id <= r.tile_id;
      req_pos_x <= r.pos_x;
      req_pos_y <= r.pos_y;
      req_pos_z <= r.pos_z;
      req_radius <= r.radius;
      req_valid <= 1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.note_request(r);
      burst_left--;
      sent++;
   endtask

   task automatic settle();
      req_valid <= 0;
      burst_left = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [trp_pkg::CSR_IDX_WIDTH-1:0] idx,
                            logic [trp_pkg::COORD_WIDTH-1:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
      csr_write <= 0;
      @(posedge clock);
   endtask

   function automatic logic [trp_pkg::COORD_WIDTH-1:0] pick_coord();
      int m;
      m = $urandom_range(0, 9);
      if (m < 8) return trp_pkg::COORD_WIDTH'(int'($urandom_range(0, 8191)) - 4096);
      if (m == 8) return trp_pkg::COORD_WIDTH'($urandom());
      return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
   endfunction

   function automatic request_type make(logic [trp_pkg::ACT_WIDTH-1:0] a, int id);
      request_type r;
      r.action = a;
      r.tile_id = trp_pkg::ID_WIDTH'(id);
      r.pos_x = pick_coord();
      r.pos_y = pick_coord();
      r.pos_z = pick_coord();
      r.radius = ($urandom_range(0, 9) == 0) ? trp_pkg::COORD_WIDTH'($urandom()) :
                 trp_pkg::COORD_WIDTH'($urandom_range(0, 2000));
      return r;
   endfunction

   task automatic send_op(logic [trp_pkg::ACT_WIDTH-1:0] a, int id);
      send(make(a, id));
   endtask

   task automatic load_at(int id, int x, int y, int z, int rd);
      request_type r;
      r = make(trp_pkg::ACT_LOAD, id);
      r.pos_x = trp_pkg::COORD_WIDTH'(x);
      r.pos_y = trp_pkg::COORD_WIDTH'(y);
      r.pos_z = trp_pkg::COORD_WIDTH'(z);
      r.radius = trp_pkg::COORD_WIDTH'(rd);
      send(r);
   endtask

   task automatic reconfigure();
      int m;
      settle();
      m = $urandom_range(0, 2);
      write_reg(trp_pkg::CSR_MAX_DISTANCE, m == 0 ? 24'd0 : m == 1 ? 24'hffffff :
                trp_pkg::COORD_WIDTH'($urandom_range(1, 6000)));
      m = $urandom_range(0, 2);
      write_reg(trp_pkg::CSR_HYSTERESIS, m == 0 ? 24'd0 : m == 1 ? 24'hffffff :
                trp_pkg::COORD_WIDTH'($urandom_range(1, 3000)));
      m = $urandom_range(0, 3);
      write_reg(trp_pkg::CSR_BUDGET, m == 0 ? 24'd0 :
                m == 1 ? trp_pkg::COORD_WIDTH'(trp_pkg::MAX_TILES) :
                trp_pkg::COORD_WIDTH'($urandom_range(1, 6)));
   endtask

   initial begin
      int n;
      int ids[$];
      reset <= 1;
      req_valid <= 0;
      req_action <= trp_pkg::ACT_LOAD;
      req_tile_id <= 0;
      req_pos_x <= 0;
      req_pos_y <= 0;
      req_pos_z <= 0;
      req_radius <= 0;
      csr_write <= 0;
      csr_index <= trp_pkg::CSR_MAX_DISTANCE;
      csr_wdata <= 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_reg(trp_pkg::CSR_MAX_DISTANCE, 24'd0);
      write_reg(trp_pkg::CSR_HYSTERESIS, 24'd0);
      write_reg(trp_pkg::CSR_BUDGET, 24'd3);
      send_op(trp_pkg::ACT_UPDATE, 0);
      send_op(trp_pkg::ACT_QUERY, 7);
      load_at(0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 0);
      load_at(31, 24'h800000, 24'h800000, 24'h800000, 24'hffffff);
      load_at(1, 100, 200, 300, 50);
      load_at(2, 100, 200, 300, 50);
      load_at(3, 100, 200, 300, 50);
      send_op(trp_pkg::ACT_MARK, 5);
      for (int i = 0; i < 4; i++) send_op(trp_pkg::ACT_MARK, i);
      send_op(trp_pkg::ACT_MARK, 31);
      send_op(trp_pkg::ACT_UPDATE, 0);
      send_op(trp_pkg::ACT_QUERY, 0);
      send_op(trp_pkg::ACT_QUERY, 31);
      send_op(trp_pkg::ACT_QUERY, 5);
      load_at(1, -3000, 0, 0, 10);
      send_op(3'd5, 0);
      send_op(3'd6, 0);
      send_op(3'd7, 31);
      send_op(trp_pkg::ACT_UPDATE, 0);
      send_op(trp_pkg::ACT_QUERY, 1);
      send_op(trp_pkg::ACT_CLEAR, 0);
      send_op(trp_pkg::ACT_QUERY, 2);
      send_op(trp_pkg::ACT_UPDATE, 0);
      settle();
      write_reg(trp_pkg::CSR_BUDGET, 24'd0);
      for (int i = 0; i < 3; i++) send_op(trp_pkg::ACT_LOAD, i);
      for (int i = 0; i < 3; i++) send_op(trp_pkg::ACT_MARK, i);
      send_op(trp_pkg::ACT_UPDATE, 0);
      settle();
      write_reg(trp_pkg::CSR_BUDGET, trp_pkg::COORD_WIDTH'(trp_pkg::MAX_TILES));
      write_reg(trp_pkg::CSR_HYSTERESIS, 24'hffffff);
      write_reg(trp_pkg::CSR_MAX_DISTANCE, 24'hffffff);

      while (sent < 410) begin
         if ($urandom_range(0, 3) == 0) reconfigure();
         if ($urandom_range(0, 9) == 0) send_op(trp_pkg::ACT_CLEAR, 0);
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++)
            send_op(trp_pkg::ACT_LOAD, $urandom_range(0, trp_pkg::MAX_TILES - 1));
         ids.delete();
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++)
            ids = {ids, int'($urandom_range(0, trp_pkg::MAX_TILES - 1))};
         foreach (ids[i]) send_op(trp_pkg::ACT_MARK, ids[i]);
         if ($urandom_range(0, 3) == 0)
            send_op(trp_pkg::ACT_WIDTH'($urandom_range(5, 7)), $urandom_range(0, 31));
         if ($urandom_range(0, 9) != 0) send_op(trp_pkg::ACT_UPDATE, $urandom_range(0, 31));
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++)
            send_op(trp_pkg::ACT_QUERY, $urandom_range(0, trp_pkg::MAX_TILES - 1));
      end

      settle();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

### tile_residency_topk_policy_core.f
+incdir+hw/rtl
hw/rtl/trp_pkg.sv
hw/rtl/trp_ram.sv
hw/rtl/trp_isqrt.sv
hw/rtl/trp_cell.sv
hw/rtl/tile_residency_topk_policy_core.sv
hw/rtl/trp_checker.sv
sim/tb_top.sv
